### hdl/closed_midpoint_quadratic_bezier_top_macros.svh
// Assertion macros shared by the closed midpoint quadratic Bezier RTL.
`ifndef CLOSED_MIDPOINT_QUADRATIC_BEZIER_TOP_MACROS_SVH
`define CLOSED_MIDPOINT_QUADRATIC_BEZIER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CMQB_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CMQB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cmqb_pkg.sv
// Types, codes and helpers shared by the closed midpoint quadratic Bezier block.
package cmqb_pkg;

   localparam int COORD_W = 16;
   localparam int COEF_W  = 20;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;

   typedef logic [1:0] seen_type;
   localparam seen_type SEEN_NONE = 2'd0;
   localparam seen_type SEEN_ONE  = 2'd1;
   localparam seen_type SEEN_TWO  = 2'd2;

   typedef enum logic [1:0] {
      ARC_SINGLE,
      ARC_MID,
      ARC_LAST,
      ARC_WRAP
   } arc_type;

   typedef struct packed {
      logic     load;
      seen_type seen;
      logic     last;
      logic     mids;
      arc_type  arc;
      logic     shift;
      logic     init;
      logic     issue;
      logic     pen;
      logic     last_point;
   } cmd_type;

   typedef struct packed {
      logic go;
   } status_type;

   function automatic coord_type mid_point(coord_type u, coord_type v);
      logic [COORD_W:0] sum;
      logic [COORD_W:0] adj;
      sum = {u[COORD_W-1], u} + {v[COORD_W-1], v};
      adj = sum + {{COORD_W{1'b0}}, sum[COORD_W]};
      return adj[COORD_W:1];
   endfunction

endpackage

### hdl/cmqb_req_if.sv
// Vertex channel: valid/ready handshake carrying one polygon vertex per item.
interface cmqb_req_if
   import cmqb_pkg::*;
;
   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   logic      last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

### hdl/cmqb_rsp_if.sv
// Sample channel: valid/ready handshake carrying one curve sample per item.
interface cmqb_rsp_if
   import cmqb_pkg::*;
;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      pen_down;
   logic      last_point;

   modport source (output valid, output point_x, output point_y, output pen_down,
                   output last_point, input ready);
   modport sink   (input valid, input point_x, input point_y, input pen_down,
                   input last_point, output ready);
endinterface

### hdl/closed_midpoint_quadratic_bezier_top.sv
// Closed midpoint quadratic Bezier top level: controller and datapath.
// Takes polygon vertices one item at a time and returns curve samples on the rsp channel.
// A vertex that completes no arc is only stored; each arc has two setup steps (midpoints,
// then forward-difference seeds) followed by SEGMENTS+1 samples, one sample per cycle
// from the forward-difference accumulator unless the rsp side holds ready low, and a
// vertex completes from 0 to 3 arcs. Samples are divided by SEGMENTS squared through a
// reciprocal multiply, two stages behind the accumulator; the next vertex is taken as
// soon as the last sample has entered them.
module closed_midpoint_quadratic_bezier_top
   import cmqb_pkg::*;
#(
   parameter int SEGMENTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   cmqb_req_if.sink   req_chan,
   cmqb_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   cmqb_ctrl #(
      .SEGMENTS (SEGMENTS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .cmd    (cmd),
      .status (status)
   );

   cmqb_dpath #(
      .SEGMENTS (SEGMENTS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .vertex_x (req_chan.vertex_x),
      .vertex_y (req_chan.vertex_y),
      .cmd      (cmd),
      .status   (status),
      .rsp      (rsp_chan)
   );

endmodule

### hdl/cmqb_ctrl.sv
// Controller: vertex count, arc sequencing and sample counter.
`include "closed_midpoint_quadratic_bezier_top_macros.svh"

module cmqb_ctrl
   import cmqb_pkg::*;
#(
   parameter int SEGMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   cmqb_req_if.sink    req,
   output cmd_type     cmd,
   input  status_type  status
);

   localparam int K_W = $clog2(SEGMENTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIDS,
      ST_INIT,
      ST_RUN
   } state_type;

   state_type      state_ff, state_in;
   seen_type       seen_ff, seen_in;
   logic           last_ff, last_in;
   arc_type        arc_ff, arc_in;
   logic [K_W-1:0] k_ff, k_in;

   logic    k_end;
   logic    has_next;
   arc_type next_arc;

   assign k_end = (k_ff == K_W'(SEGMENTS));

   always_comb begin
      has_next = 1'b0;
      next_arc = ARC_SINGLE;
      case (arc_ff)
         ARC_MID: begin
            has_next = last_ff;
            next_arc = ARC_LAST;
         end
         ARC_LAST: begin
            has_next = 1'b1;
            next_arc = ARC_WRAP;
         end
         default: begin
            has_next = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      last_in   = last_ff;
      arc_in    = arc_ff;
      k_in      = k_ff;
      req.ready = 1'b0;
      cmd       = '0;
      cmd.seen  = seen_ff;
      cmd.last  = req.last_vertex;
      cmd.arc   = arc_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd.load = 1'b1;
               last_in  = req.last_vertex;
               case (seen_ff)
                  SEEN_NONE: begin
                     if (req.last_vertex) begin
                        arc_in   = ARC_SINGLE;
                        state_in = ST_MIDS;
                     end else begin
                        seen_in = SEEN_ONE;
                     end
                  end
                  SEEN_ONE: begin
                     if (req.last_vertex) begin
                        arc_in   = ARC_LAST;
                        seen_in  = SEEN_NONE;
                        state_in = ST_MIDS;
                     end else begin
                        seen_in = SEEN_TWO;
                     end
                  end
                  default: begin
                     arc_in   = ARC_MID;
                     seen_in  = req.last_vertex ? SEEN_NONE : SEEN_TWO;
                     state_in = ST_MIDS;
                  end
               endcase
            end
         end
         ST_MIDS: begin
            cmd.mids  = 1'b1;
            cmd.shift = (arc_ff == ARC_MID) && !last_ff;
            state_in  = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            k_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.issue      = status.go;
            cmd.pen        = (k_ff != '0);
            cmd.last_point = k_end && !has_next;
            if (status.go) begin
               if (k_end) begin
                  k_in = '0;
                  if (has_next) begin
                     arc_in   = next_arc;
                     state_in = ST_MIDS;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  k_in = k_ff + K_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= SEEN_NONE;
         last_ff  <= 1'b0;
         arc_ff   <= ARC_SINGLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         last_ff  <= last_in;
         arc_ff   <= arc_in;
         k_ff     <= k_in;
      end
   end

   `CMQB_ASSERT_NOW(a_seen_saturates, 1'b1, seen_ff == SEEN_NONE || seen_ff == SEEN_ONE || seen_ff == SEEN_TWO, "vertex count beyond two")
   `CMQB_ASSERT_NEXT(a_third_vertex_arc, state_ff == ST_IDLE && req.valid && seen_ff == SEEN_TWO, state_ff == ST_MIDS && arc_ff == ARC_MID, "third vertex did not start an arc")
   `CMQB_ASSERT_NEXT(a_arc_runs_full, state_ff == ST_RUN && !k_end, state_ff == ST_RUN, "arc left before its last sample")

endmodule

### hdl/cmqb_dpath.sv
// Datapath: vertex store, control points, forward differences and exact division.
`include "closed_midpoint_quadratic_bezier_top_macros.svh"

module cmqb_dpath
   import cmqb_pkg::*;
#(
   parameter int SEGMENTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  coord_type  vertex_x,
   input  coord_type  vertex_y,
   input  cmd_type    cmd,
   output status_type status,
   cmqb_rsp_if.source rsp
);

   localparam int SEG_SQ  = SEGMENTS * SEGMENTS;
   localparam int SQ_LOG  = $clog2(SEG_SQ);
   localparam int MAG_W   = COORD_W + SQ_LOG;
   localparam int NUM_W   = MAG_W + 1;
   localparam int DIF_W   = MAG_W + 2;
   localparam int SHIFT   = MAG_W + SQ_LOG;
   localparam int RECIP_W = MAG_W + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam logic [SHIFT:0] ONE_SHIFTED = (SHIFT + 1)'(1) << SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((ONE_SHIFTED + SEG_SQ - 1) / SEG_SQ);

   logic      go;
   logic      p1_valid_ff;
   logic      p1_pen_ff;
   logic      p1_last_ff;
   logic      out_valid_ff;
   logic      out_pen_ff;
   logic      out_last_ff;

   assign go        = !out_valid_ff || rsp.ready;
   assign status.go = go;

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      coord_type vin;
      coord_type first_ff, second_ff, prev_ff, bprev_ff, cur_ff;
      coord_type src_a, src_p, src_b;
      coord_type q0_ff, q1_ff, q2_ff;
      coef_type  coef_a, coef_b;
      logic signed [31:0] b_times_n;
      logic signed [NUM_W-1:0] num_ff;
      logic signed [DIF_W-1:0] dif_ff, ddif_ff;
      logic [MAG_W-1:0]   mag;
      logic               p1_sign_ff;
      logic [PROD_W-1:0]  p1_prod_ff;
      logic [COORD_W:0]   quo;
      coord_type          out_pt_ff;

      assign vin = (ln == 0) ? vertex_x : vertex_y;

      always_comb begin
         src_a = cur_ff;
         src_p = cur_ff;
         src_b = cur_ff;
         case (cmd.arc)
            ARC_MID: begin
               src_a = bprev_ff;
               src_p = prev_ff;
               src_b = cur_ff;
            end
            ARC_LAST: begin
               src_a = prev_ff;
               src_p = cur_ff;
               src_b = first_ff;
            end
            ARC_WRAP: begin
               src_a = cur_ff;
               src_p = first_ff;
               src_b = second_ff;
            end
            default: begin
               src_a = cur_ff;
            end
         endcase
      end

      assign coef_a    = COEF_W'(q0_ff) - (COEF_W'(q1_ff) <<< 1) + COEF_W'(q2_ff);
      assign coef_b    = (COEF_W'(q1_ff) - COEF_W'(q0_ff)) <<< 1;
      assign b_times_n = 32'(coef_b) * SEGMENTS;
      assign mag       = MAG_W'(num_ff[NUM_W-1] ? -num_ff : num_ff);
      assign quo       = p1_prod_ff[SHIFT +: COORD_W + 1];

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            cur_ff <= vin;
            case (cmd.seen)
               SEEN_NONE: begin
                  first_ff <= vin;
                  prev_ff  <= vin;
               end
               SEEN_ONE: begin
                  second_ff <= vin;
                  if (!cmd.last) begin
                     bprev_ff <= prev_ff;
                     prev_ff  <= vin;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.shift) begin
            bprev_ff <= prev_ff;
            prev_ff  <= cur_ff;
         end
         if (cmd.mids) begin
            q0_ff <= mid_point(src_a, src_p);
            q1_ff <= src_p;
            q2_ff <= mid_point(src_p, src_b);
         end
         if (cmd.init) begin
            num_ff  <= NUM_W'(32'(q0_ff) * SEG_SQ);
            dif_ff  <= DIF_W'(32'(coef_a) + b_times_n);
            ddif_ff <= DIF_W'(32'(coef_a) <<< 1);
         end else if (cmd.issue) begin
            num_ff <= num_ff + NUM_W'(dif_ff);
            dif_ff <= dif_ff + ddif_ff;
         end
         if (go) begin
            p1_sign_ff <= num_ff[NUM_W-1];
            p1_prod_ff <= PROD_W'(mag) * PROD_W'(RECIP);
            out_pt_ff  <= COORD_W'(p1_sign_ff ? -quo : quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (go) begin
         p1_valid_ff  <= cmd.issue;
         out_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         p1_pen_ff   <= cmd.pen;
         p1_last_ff  <= cmd.last_point;
         out_pen_ff  <= p1_pen_ff;
         out_last_ff <= p1_last_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.point_x    = g_lane[0].out_pt_ff;
   assign rsp.point_y    = g_lane[1].out_pt_ff;
   assign rsp.pen_down   = out_pen_ff;
   assign rsp.last_point = out_last_ff;

   `CMQB_ASSERT_NOW(a_issue_needs_room, cmd.issue, go, "sample issued while the pipeline is stalled")
   `CMQB_ASSERT_NOW(a_first_not_last, out_valid_ff && !out_pen_ff, !out_last_ff, "first sample of an arc marked last")

endmodule

### dv/tb_closed_midpoint_quadratic_bezier_top.sv
// Testbench for the closed midpoint quadratic Bezier top: directed and random polygons.
module tb_closed_midpoint_quadratic_bezier_top;
   import cmqb_pkg::*;

   localparam int SEGMENTS = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 110;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      pen_down;
      logic      last_point;
   } curve_sample_type;

   typedef struct {
      int x;
      int y;
   } vertex_type;

   class curve_scoreboard;
      curve_sample_type samples_due[$];
      int               fails;
      vertex_type       first_v;
      vertex_type       second_v;
      vertex_type       prev_v;
      vertex_type       before_prev_v;
      int               seen;

      function new();
         first_v       = '{0, 0};
         second_v      = '{0, 0};
         prev_v        = '{0, 0};
         before_prev_v = '{0, 0};
         seen          = 0;
         fails         = 0;
      endfunction

      function int halve(int u, int v);
         return (u + v) / 2;
      endfunction

      function coord_type arc_coord(int q0, int q1, int q2, longint k);
         longint n;
         longint a;
         longint b;
         longint c;
         n = SEGMENTS;
         a = longint'(q0) - 2 * longint'(q1) + longint'(q2);
         b = 2 * (longint'(q1) - longint'(q0));
         c = q0;
         return coord_type'((a * k * k + b * k * n + c * n * n) / (n * n));
      endfunction

      function void add_arc(vertex_type a, vertex_type p, vertex_type b);
         int               m0x;
         int               m0y;
         int               m1x;
         int               m1y;
         curve_sample_type s;
         m0x = halve(a.x, p.x);
         m0y = halve(a.y, p.y);
         m1x = halve(p.x, b.x);
         m1y = halve(p.y, b.y);
         for (int k = 0; k <= SEGMENTS; k++) begin
            s.x          = arc_coord(m0x, p.x, m1x, k);
            s.y          = arc_coord(m0y, p.y, m1y, k);
            s.pen_down   = (k != 0);
            s.last_point = 1'b0;
            samples_due.push_back(s);
         end
      endfunction

      function void note_vertex(coord_type vx, coord_type vy, logic closing);
         vertex_type v;
         int         depth;
         v.x   = vx;
         v.y   = vy;
         depth = samples_due.size();
         if (seen == 0) begin
            first_v = v;
            prev_v  = v;
            if (closing) begin
               add_arc(v, v, v);
            end else begin
               seen = 1;
            end
         end else begin
            if (seen == 1) begin
               second_v = v;
            end else begin
               add_arc(before_prev_v, prev_v, v);
            end
            if (closing) begin
               add_arc(prev_v, v, first_v);
               add_arc(v, first_v, second_v);
               seen = 0;
            end else begin
               before_prev_v = prev_v;
               prev_v        = v;
               seen          = 2;
            end
         end
         if (samples_due.size() > depth) begin
            samples_due[samples_due.size() - 1].last_point = 1'b1;
         end
      endfunction

      function void check_sample(curve_sample_type got);
         curve_sample_type want;
         if (samples_due.size() == 0) begin
            fails++;
            $display("%0t: expected no sample, got x=%0d y=%0d pen=%0b last=%0b", $time,
                     got.x, got.y, got.pen_down, got.last_point);
            return;
         end
         want = samples_due.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.pen_down !== want.pen_down ||
             got.last_point !== want.last_point) begin
            fails++;
            $display("%0t: expected x=%0d y=%0d pen=%0b last=%0b, %s", $time,
                     want.x, want.y, want.pen_down, want.last_point,
                     $sformatf("got x=%0d y=%0d pen=%0b last=%0b",
                               got.x, got.y, got.pen_down, got.last_point));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned cycle_count;
   int          sender_idle_pct;
   int          rsp_stall_pct;

   curve_scoreboard sb;

   cmqb_req_if req_chan ();
   cmqb_rsp_if rsp_chan ();

   closed_midpoint_quadratic_bezier_top #(
      .SEGMENTS(SEGMENTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_sample({rsp_chan.point_x, rsp_chan.point_y, rsp_chan.pen_down,
                          rsp_chan.last_point});
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic coord_type rand_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(3))
            0: return coord_type'(-32768);
            1: return coord_type'(32767);
            2: return coord_type'(-1);
            default: return coord_type'(0);
         endcase
      end else if (pick < 35) begin
         return coord_type'(int'($urandom_range(40)) - 20);
      end
      return coord_type'($urandom);
   endfunction

   task automatic send_vertex(coord_type vx, coord_type vy, logic closing);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.vertex_x    <= vx;
      req_chan.vertex_y    <= vy;
      req_chan.last_vertex <= closing;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_vertex(vx, vy, closing);
   endtask

   task automatic send_polygon(ref int sent);
      int count;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         count = 1;
      end else if (pick < 20) begin
         count = 2;
      end else begin
         count = $urandom_range(10, 3);
      end
      for (int i = 0; i < count; i++) begin
         send_vertex(rand_coord(), rand_coord(), i == count - 1);
      end
      sent += count;
   endtask

   int dir_x[18] = '{32767, -32768, -32768, 32767, -3, -1, 4, -32768, 32767, 32767, -32768,
                     -32767, -5, 32767, -1, 7, 0, -1};
   int dir_y[18] = '{-32768, 32767, -32768, 32767, 5, -7, -2, -32768, -32768, 32767, 32767,
                     1, -32768, 3, -1, 32766, 0, -1};
   bit dir_last[18] = '{1, 1, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 1};

   initial begin
      int sent;
      sb = new();
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.vertex_x    <= '0;
      req_chan.vertex_y    <= '0;
      req_chan.last_vertex <= 1'b0;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 18; i++) begin
         send_vertex(coord_type'(dir_x[i]), coord_type'(dir_y[i]), dir_last[i]);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 0;
            end
            1: begin
               sender_idle_pct = 85;
               rsp_stall_pct   = 0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct   = 85;
            end
            default: begin
               sender_idle_pct = 37;
               rsp_stall_pct   = 37;
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) send_polygon(sent);
      end

      req_chan.valid <= 1'b0;
      while (sb.samples_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fails == 0 && sb.samples_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
